// File: rtl/fcrc_pkg.sv
// ----------------------------------------------------------------------------
// fcrc_pkg: shared types and constants of the floppy command/result controller
// Bus action codes, phases, opcode values, status bytes and the opcode decoder.
// ----------------------------------------------------------------------------
package fcrc_pkg;

   // Drive geometry: a track number at or above MAX_TRACKS - 1 is out of range
   localparam int unsigned MAX_TRACKS  = 80;
   localparam logic [7:0]  TRACK_LIMIT = 8'(MAX_TRACKS - 1);

   // Stored command bytes (only bytes 0..5 are ever looked at) and result bytes
   localparam int unsigned CMD_STORE_DEPTH = 6;
   localparam int unsigned RES_DEPTH       = 7;
   localparam logic [3:0]  CMD_COUNT_MAX   = 4'd15;

   // Bus access kinds
   typedef enum logic [1:0] {
      ACT_FIFO_WRITE  = 2'd0,
      ACT_FIFO_READ   = 2'd1,
      ACT_STATUS_READ = 2'd2,
      ACT_SET_PARAMS  = 2'd3
   } act_type;

   // Controller phases
   typedef enum logic [1:0] {
      PH_CMD    = 2'd0,
      PH_EXEC   = 2'd1,
      PH_RESULT = 2'd2
   } phase_type;

   // Decoded command action
   typedef enum logic [3:0] {
      OP_WAIT,
      OP_INVALID,
      OP_READ,
      OP_WRITE,
      OP_RECAL,
      OP_SEEK,
      OP_SENSE_INT,
      OP_SPECIFY,
      OP_OTHER
   } op_type;

   // Full-byte opcodes
   localparam logic [7:0] OPC_SPECIFY     = 8'h03;
   localparam logic [7:0] OPC_SENSE_DRIVE = 8'h04;
   localparam logic [7:0] OPC_RECAL       = 8'h07;
   localparam logic [7:0] OPC_SENSE_INT   = 8'h08;
   localparam logic [7:0] OPC_SEEK        = 8'h0F;

   // Opcodes matched on their low five bits
   localparam logic [4:0] OPC_READ_TRACK   = 5'h02;
   localparam logic [4:0] OPC_WRITE_DATA   = 5'h05;
   localparam logic [4:0] OPC_READ_DATA    = 5'h06;
   localparam logic [4:0] OPC_WRITE_DELETE = 5'h09;
   localparam logic [4:0] OPC_READ_ID      = 5'h0A;
   localparam logic [4:0] OPC_READ_DELETE  = 5'h0C;
   localparam logic [4:0] OPC_FORMAT       = 5'h0D;
   localparam logic [4:0] OPC_SCAN_EQ      = 5'h11;
   localparam logic [4:0] OPC_SCAN_LE      = 5'h19;
   localparam logic [4:0] OPC_SCAN_HE      = 5'h1D;

   // Main status values and result status bytes
   localparam logic [7:0] MSR_CMD      = 8'h80;
   localparam logic [7:0] MSR_EXEC     = 8'h10;
   localparam logic [7:0] MSR_RESULT   = 8'hD0;
   localparam logic [7:0] MSR_NONE     = 8'h00;
   localparam logic [7:0] ST0_INVALID  = 8'h80;
   localparam logic [7:0] ST0_ABNORMAL = 8'hC8;
   localparam logic [7:0] ST0_NOT_RDY  = 8'h60;
   localparam logic [7:0] ST0_SEEK_END = 8'h20;
   localparam logic [7:0] NO_DATA      = 8'hFF;

   // Request payload, lowest bits first: data_byte, drive_select, head_select,
   // motor_enable, zero fill
   typedef struct packed {
      logic [4:0] fill;
      logic       motor_enable;
      logic       head_select;
      logic       drive_select;
      logic [7:0] data_byte;
   } req_data_type;

   // Response payload, lowest bits first: fifo_byte, status_byte,
   // interrupt_pending, flush_request, zero fill
   typedef struct packed {
      logic [5:0] fill;
      logic       flush_request;
      logic       interrupt_pending;
      logic [7:0] status_byte;
      logic [7:0] fifo_byte;
   } rsp_data_type;

   // Decode opcode byte against the byte count after this write
   function automatic op_type cmd_decode(input logic [7:0] opcode,
                                         input logic [3:0] count);
      op_type     op;
      logic [3:0] len;
      op  = OP_INVALID;
      len = 4'd0;
      unique case (opcode)
         OPC_SPECIFY:     begin op = OP_SPECIFY;   len = 4'd3;  end
         OPC_SENSE_DRIVE: begin op = OP_OTHER;     len = 4'd2;  end
         OPC_RECAL:       begin op = OP_RECAL;     len = 4'd2;  end
         OPC_SENSE_INT:   begin op = OP_SENSE_INT; len = count; end
         OPC_SEEK:        begin op = OP_SEEK;      len = 4'd3;  end
         default: begin
            unique case (opcode[4:0])
               OPC_READ_TRACK:   begin op = OP_OTHER; len = 4'd9; end
               OPC_WRITE_DATA,
               OPC_WRITE_DELETE: begin op = OP_WRITE; len = 4'd9; end
               OPC_READ_DATA,
               OPC_READ_DELETE:  begin op = OP_READ;  len = 4'd9; end
               OPC_READ_ID:      begin op = OP_OTHER; len = 4'd2; end
               OPC_FORMAT:       begin op = OP_OTHER; len = 4'd6; end
               OPC_SCAN_EQ,
               OPC_SCAN_LE,
               OPC_SCAN_HE:      begin op = OP_OTHER; len = 4'd9; end
               default:          begin op = OP_INVALID; len = 4'd0; end
            endcase
         end
      endcase
      if (op != OP_INVALID && count != len) begin
         op = OP_WAIT;
      end
      return op;
   endfunction

endpackage

// File: rtl/floppy_command_result_controller.sv
// ----------------------------------------------------------------------------
// floppy_command_result_controller: 8272-style command/result handshake
// Collects command bytes, decodes them, builds result bytes and main status.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the req_ stream is one bus access, selected by req_tuser:
//   fifo write, fifo read, status read or set drive parameters. Every request
//   gives exactly one response on the rsp_ stream carrying the fifo read byte,
//   the main status byte, the interrupt flag and a flush flag that marks the
//   motor turning off.
//   The csr_ port writes the attached-drive mask; write it only while no
//   request is in flight.
// Latency and throughput:
//   A request is decoded and the state updated in the cycle it is accepted;
//   its response sits in the response register from the next cycle on. One
//   request per cycle unless stalled, set by the single state update stage.
// Reset:
//   Synchronous reset returns to command phase with empty counters, interrupt
//   and motor off, drive 0 selected and no drive attached.
// Stall:
//   While the receiver holds rsp_tready low the response register holds its
//   response and req_tready drops; a request is still taken in the same cycle
//   that the waiting response leaves.
// ----------------------------------------------------------------------------
module floppy_command_result_controller (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // data_byte[7:0], drive_select[8],
                                    // head_select[9], motor_enable[10], zero
   input  logic [1:0]  req_tuser,   // action[1:0]
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // fifo_byte[7:0], status_byte[15:8],
                                    // interrupt_pending[16], flush_request[17],
                                    // zero
   // configuration
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data  // attached_mask[1:0]
);

   // Request handshake and payload views
   fcrc_pkg::req_data_type req_data;
   fcrc_pkg::act_type      req_action;
   logic                   req_fire;

   // Control state
   fcrc_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          cmd_count_ff, cmd_count_in;
   logic [2:0]          res_len_ff, res_len_in;
   logic [2:0]          res_pos_ff, res_pos_in;
   logic                irq_ff, irq_in;
   logic                motor_ff, motor_in;
   logic                drive_ff, drive_in;
   logic [1:0]          attached_ff;

   // Command and result byte stores (no reset: read only after written)
   logic [7:0] cmd_byte_ff [fcrc_pkg::CMD_STORE_DEPTH];
   logic [7:0] cmd_byte_in [fcrc_pkg::CMD_STORE_DEPTH];
   logic [7:0] res_byte_ff [fcrc_pkg::RES_DEPTH];
   logic [7:0] res_byte_in [fcrc_pkg::RES_DEPTH];

   // Response register
   logic                   rsp_valid_ff;
   fcrc_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   // Decode helpers
   logic [7:0]       opcode;
   fcrc_pkg::op_type op;
   logic             drive_ready;
   logic [1:0]       unit;
   logic             bad_transfer;
   logic [7:0]       read_byte;
   logic             flush;

   assign req_data   = fcrc_pkg::req_data_type'(req_tdata);
   assign req_action = fcrc_pkg::act_type'(req_tuser);

   // Take a new request whenever the response slot is empty or draining
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_fire   = req_tvalid & req_tready;

   assign drive_ready  = attached_ff[drive_ff];
   assign unit         = cmd_byte_ff[1][1:0];
   assign bad_transfer = ~drive_ready || (cmd_byte_ff[2] >= fcrc_pkg::TRACK_LIMIT);

   // Opcode is the incoming byte when it is the first of a command
   assign opcode = (cmd_count_ff == 4'd0) ? req_data.data_byte : cmd_byte_ff[0];

   // Next state and response for the request at the input
   always_comb begin
      phase_in     = phase_ff;
      cmd_count_in = cmd_count_ff;
      res_len_in   = res_len_ff;
      res_pos_in   = res_pos_ff;
      irq_in       = irq_ff;
      motor_in     = motor_ff;
      drive_in     = drive_ff;
      cmd_byte_in  = cmd_byte_ff;
      res_byte_in  = res_byte_ff;
      read_byte    = fcrc_pkg::NO_DATA;
      flush        = 1'b0;
      op           = fcrc_pkg::OP_WAIT;

      unique case (req_action)
         fcrc_pkg::ACT_FIFO_WRITE: begin
            if (phase_ff == fcrc_pkg::PH_CMD) begin
               irq_in = 1'b0;
               // store only the bytes that later decode looks at
               if (cmd_count_ff < 4'(fcrc_pkg::CMD_STORE_DEPTH)) begin
                  cmd_byte_in[cmd_count_ff[2:0]] = req_data.data_byte;
               end
               if (cmd_count_ff != fcrc_pkg::CMD_COUNT_MAX) begin
                  cmd_count_in = cmd_count_ff + 4'd1;
               end
               op = fcrc_pkg::cmd_decode(opcode, cmd_count_in);
               unique case (op)
                  fcrc_pkg::OP_WAIT: begin
                  end
                  fcrc_pkg::OP_INVALID: begin
                     phase_in       = fcrc_pkg::PH_RESULT;
                     res_byte_in[0] = fcrc_pkg::ST0_INVALID;
                     res_len_in     = 3'd1;
                     res_pos_in     = 3'd0;
                     cmd_count_in   = 4'd0;
                  end
                  default: begin
                     // start the command: default to execute phase
                     cmd_count_in = 4'd0;
                     res_len_in   = 3'd0;
                     res_pos_in   = 3'd0;
                     phase_in     = fcrc_pkg::PH_EXEC;
                     unique case (op)
                        fcrc_pkg::OP_READ, fcrc_pkg::OP_WRITE: begin
                           phase_in       = fcrc_pkg::PH_RESULT;
                           res_byte_in[0] = bad_transfer
                                            ? (fcrc_pkg::ST0_ABNORMAL | {6'd0, unit})
                                            : (fcrc_pkg::ST0_SEEK_END | {6'd0, unit});
                           res_byte_in[1] = 8'h00;
                           res_byte_in[2] = 8'h00;
                           res_byte_in[3] = cmd_byte_ff[2];
                           res_byte_in[4] = cmd_byte_ff[3];
                           res_byte_in[5] = cmd_byte_ff[4];
                           res_byte_in[6] = cmd_byte_ff[5];
                           res_len_in     = 3'd7;
                           irq_in         = 1'b1;
                        end
                        fcrc_pkg::OP_RECAL, fcrc_pkg::OP_SEEK: begin
                           phase_in = fcrc_pkg::PH_CMD;
                           irq_in   = 1'b1;
                        end
                        fcrc_pkg::OP_SENSE_INT: begin
                           phase_in       = fcrc_pkg::PH_RESULT;
                           res_byte_in[0] = drive_ready ? fcrc_pkg::ST0_SEEK_END
                                                        : fcrc_pkg::ST0_NOT_RDY;
                           res_byte_in[1] = 8'h00;
                           res_len_in     = 3'd2;
                           irq_in         = 1'b0;
                        end
                        fcrc_pkg::OP_SPECIFY: begin
                           phase_in = fcrc_pkg::PH_CMD;
                        end
                        default: begin
                           // unimplemented command: park in execute phase
                        end
                     endcase
                  end
               endcase
            end
         end
         fcrc_pkg::ACT_FIFO_READ: begin
            if (phase_ff == fcrc_pkg::PH_RESULT) begin
               irq_in = 1'b0;
               if (res_pos_ff < res_len_ff && res_pos_ff != 3'(fcrc_pkg::RES_DEPTH)) begin
                  read_byte  = res_byte_ff[res_pos_ff];
                  res_pos_in = res_pos_ff + 3'd1;
               end
               // back to command phase once every result byte is out
               if (res_pos_in >= res_len_ff) begin
                  phase_in = fcrc_pkg::PH_CMD;
               end
            end
         end
         fcrc_pkg::ACT_STATUS_READ: begin
         end
         fcrc_pkg::ACT_SET_PARAMS: begin
            // head_select is accepted and has no effect
            drive_in = req_data.drive_select;
            flush    = motor_ff & ~req_data.motor_enable;
            motor_in = req_data.motor_enable;
         end
         default: begin
         end
      endcase

      rsp_data_in                   = '0;
      rsp_data_in.fifo_byte         = read_byte;
      rsp_data_in.interrupt_pending = irq_in;
      rsp_data_in.flush_request     = flush;
      unique case (phase_in)
         fcrc_pkg::PH_CMD:    rsp_data_in.status_byte = fcrc_pkg::MSR_CMD;
         fcrc_pkg::PH_EXEC:   rsp_data_in.status_byte = fcrc_pkg::MSR_EXEC;
         fcrc_pkg::PH_RESULT: rsp_data_in.status_byte = fcrc_pkg::MSR_RESULT;
         default:             rsp_data_in.status_byte = fcrc_pkg::MSR_NONE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= fcrc_pkg::PH_CMD;
         cmd_count_ff <= 4'd0;
         res_len_ff   <= 3'd0;
         res_pos_ff   <= 3'd0;
         irq_ff       <= 1'b0;
         motor_ff     <= 1'b0;
         drive_ff     <= 1'b0;
         attached_ff  <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff     <= phase_in;
            cmd_count_ff <= cmd_count_in;
            res_len_ff   <= res_len_in;
            res_pos_ff   <= res_pos_in;
            irq_ff       <= irq_in;
            motor_ff     <= motor_in;
            drive_ff     <= drive_in;
         end
         if (csr_wr_en) begin
            attached_ff <= csr_wr_data;
         end
         // hold the response until taken, refill on a new request
         rsp_valid_ff <= req_fire | (rsp_valid_ff & ~rsp_tready);
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_byte_ff <= cmd_byte_in;
         res_byte_ff <= res_byte_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Read pointer never runs past the result length
   assert property (@(posedge clock) disable iff (reset)
      res_pos_ff <= res_len_ff)
      else $error("result position beyond result length");

   // Result phase always has result bytes to hand out
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == fcrc_pkg::PH_RESULT) |-> (res_len_ff != 3'd0 && res_pos_ff < res_len_ff))
      else $error("result phase with no result byte left");

   // Commands are decoded by their ninth byte at the latest
   assert property (@(posedge clock) disable iff (reset)
      cmd_count_ff <= 4'd8)
      else $error("command byte count ran past the longest command");

   // A status read leaves phase, interrupt, command count and read position untouched
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_action == fcrc_pkg::ACT_STATUS_READ) |=>
         ($stable(phase_ff) && $stable(irq_ff) && $stable(cmd_count_ff)
          && $stable(res_pos_ff)))
      else $error("status read changed controller state");

   // A flush is only reported for a motor that was running
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && rsp_data_in.flush_request) |-> (motor_ff && !motor_in))
      else $error("flush without motor turning off");

endmodule
